>>> rtl/core/lc2k_pkg.sv
// ============================================================================
// lc2k_pkg
// shared types, codes and field positions for the lc2k instruction executor
// ============================================================================
package lc2k_pkg;

    // memory depth must be a power of two from 256 to 65536
    localparam int MEM_WORDS_DEF = 65536;
    localparam int NUM_REGS      = 8;

    localparam int WORD_W   = 32;
    localparam int ADDR_W   = 16;
    localparam int REG_IDX_W = 3;

    // command carried in the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // instruction word fields
    localparam int OP_HI   = 24;
    localparam int OP_LO   = 22;
    localparam int RA_HI   = 21;
    localparam int RA_LO   = 19;
    localparam int RB_HI   = 18;
    localparam int RB_LO   = 16;
    localparam int RD_HI   = 2;
    localparam int RD_LO   = 0;
    localparam int OFF_HI  = 15;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NAND = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } opcode_t;

    typedef struct packed {
        logic                 halted;
        logic [ADDR_W-1:0]    pc;
        logic                 reg_written;
        logic [REG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    reg_value;
        logic                 mem_written;
        logic [ADDR_W-1:0]    mem_address;
        logic [WORD_W-1:0]    mem_value;
        logic [WORD_W-1:0]    executed_count;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                 re;
        logic [REG_IDX_W-1:0] raddr_a;
        logic [REG_IDX_W-1:0] raddr_b;
        logic                 we;
        logic [REG_IDX_W-1:0] waddr;
        logic [WORD_W-1:0]    wdata;
    } rf_req_t;

    function automatic logic [WORD_W-1:0] sext16(input logic [WORD_W-1:0] word);
        sext16 = {{(WORD_W-16){word[OFF_HI]}}, word[OFF_HI:0]};
    endfunction

endpackage

>>> rtl/core/lc2k_mem.sv
// ============================================================================
// lc2k_mem
// unified instruction and data memory, one write and one registered read port
// ============================================================================
module lc2k_mem
    import lc2k_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [WORD_W-1:0] mem_array [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_array[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem_array[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lc2k_regfile.sv
// ============================================================================
// lc2k_regfile
// eight-entry register file, two registered read ports, one write port
// ============================================================================
module lc2k_regfile
    import lc2k_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  rf_req_t           req,
    output logic [WORD_W-1:0] rdata_a,
    output logic [WORD_W-1:0] rdata_b
);

    logic [WORD_W-1:0]   regs_array [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [WORD_W-1:0]   rd_a_reg;
    logic [WORD_W-1:0]   rd_b_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;

    // entries not yet written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.we) begin
            vld_reg[req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.we) begin
            regs_array[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_a_reg  <= regs_array[req.raddr_a];
            rd_b_reg  <= regs_array[req.raddr_b];
            vld_a_reg <= vld_reg[req.raddr_a];
            vld_b_reg <= vld_reg[req.raddr_b];
        end
    end

    assign rdata_a = vld_a_reg ? rd_a_reg : '0;
    assign rdata_b = vld_b_reg ? rd_b_reg : '0;

endmodule

>>> rtl/core/lc2k_instruction_executor.sv
// ============================================================================
// lc2k_instruction_executor
// lc2k machine: memory load and single-step execution with one result per item
// ============================================================================
// usage:
//   s_ channel carries one command per item: tuser selects load (0) or step
//   (1); a load writes tdata's data word at tdata's address, a step runs the
//   instruction at pc. every item returns exactly one m_ item with the new
//   pc, halt flag, register and memory writes and the executed count.
// sequence per item:
//   load, or step after halt: result registered straight from the idle state
//   add, nand, sw, beq, jalr, halt, noop: fetch read, register read and
//   execute in turn; lw adds an extra data read on the same memory port
//   one item is in flight at a time; the next is taken once the result is
//   registered in the output register
// reset:
//   pc, halt flag, count and all registers clear; memory is not cleared and
//   must be loaded before it is fetched or read
// stall:
//   a result waiting in the output register does not block the next item;
//   a second finished result is held until m_tready frees the output
// ============================================================================
module lc2k_instruction_executor
    import lc2k_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // load_address, load_data
    input  logic [0:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // program_counter, reg_index, reg_value,
                                    // mem_address, mem_value, executed_count
    output logic [2:0]   m_tuser    // halted, reg_written, mem_written
);

    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'(MEM_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_LOAD,
        S_PUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   pc_reg, pc_next;
    logic                halt_reg, halt_next;
    logic [WORD_W-1:0]   cnt_reg, cnt_next;
    logic [WORD_W-1:0]   instr_reg, instr_next;
    logic                m_valid_reg, m_valid_next;
    res_t                out_reg, out_next;
    res_t                hold_reg, hold_next;

    mem_req_t            mem_req;
    rf_req_t             rf_req;
    logic [WORD_W-1:0]   mem_rdata;
    logic [WORD_W-1:0]   va;
    logic [WORD_W-1:0]   vb;

    logic                fin_valid;
    res_t                fin_res;
    logic                out_free;
    opcode_t             op;
    logic [REG_IDX_W-1:0] ra_idx, rb_idx, rd_idx;
    logic [WORD_W-1:0]   off32;
    logic [WORD_W-1:0]   eff_addr;
    logic [ADDR_W-1:0]   pc_inc;
    logic [ADDR_W-1:0]   br_target;

    lc2k_mem #(
        .MEM_WORDS(MEM_WORDS)
    ) u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    lc2k_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rf_req),
        .rdata_a (va),
        .rdata_b (vb)
    );

    assign out_free = !m_valid_reg || m_tready;

    assign op        = opcode_t'(instr_reg[OP_HI:OP_LO]);
    assign ra_idx    = instr_reg[RA_HI:RA_LO];
    assign rb_idx    = instr_reg[RB_HI:RB_LO];
    assign rd_idx    = instr_reg[RD_HI:RD_LO];
    assign off32     = sext16(instr_reg);
    assign eff_addr  = va + off32;
    assign pc_inc    = (pc_reg + ADDR_W'(1)) & ADDR_MASK;
    assign br_target = (pc_reg + ADDR_W'(1) + instr_reg[OFF_HI:0]) & ADDR_MASK;

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        halt_next    = halt_reg;
        cnt_next     = cnt_reg;
        instr_next   = instr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        out_next     = out_reg;
        hold_next    = hold_reg;
        mem_req      = '0;
        rf_req       = '0;
        fin_valid    = 1'b0;
        fin_res      = '0;
        s_tready     = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == CMD_LOAD) begin
                        mem_req.we   = 1'b1;
                        mem_req.waddr = s_tdata[15:0] & ADDR_MASK;
                        mem_req.wdata = s_tdata[47:16];
                        fin_valid    = 1'b1;
                    end else if (halt_reg) begin
                        fin_valid = 1'b1;
                    end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = pc_reg;
                        state_next    = S_DECODE;
                    end
                    fin_res.halted         = halt_reg;
                    fin_res.pc             = pc_reg;
                    fin_res.executed_count = cnt_reg;
                end
            end
            S_DECODE: begin
                instr_next     = mem_rdata;
                rf_req.re      = 1'b1;
                rf_req.raddr_a = mem_rdata[RA_HI:RA_LO];
                rf_req.raddr_b = mem_rdata[RB_HI:RB_LO];
                state_next     = S_EXEC;
            end
            S_EXEC: begin
                pc_next  = pc_inc;
                cnt_next = cnt_reg + WORD_W'(1);
                unique case (op)
                    OP_ADD: begin
                        rf_req.we    = 1'b1;
                        rf_req.waddr = rd_idx;
                        rf_req.wdata = va + vb;
                    end
                    OP_NAND: begin
                        rf_req.we    = 1'b1;
                        rf_req.waddr = rd_idx;
                        rf_req.wdata = ~(va & vb);
                    end
                    OP_LW: begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = eff_addr[ADDR_W-1:0] & ADDR_MASK;
                    end
                    OP_SW: begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = eff_addr[ADDR_W-1:0] & ADDR_MASK;
                        mem_req.wdata = vb;
                    end
                    OP_BEQ: begin
                        if (va == vb) begin
                            pc_next = br_target;
                        end
                    end
                    OP_JALR: begin
                        rf_req.we    = 1'b1;
                        rf_req.waddr = rb_idx;
                        rf_req.wdata = {{(WORD_W-ADDR_W){1'b0}}, pc_inc};
                        if (ra_idx != rb_idx) begin
                            pc_next = va[ADDR_W-1:0] & ADDR_MASK;
                        end
                    end
                    OP_HALT: begin
                        halt_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
                fin_res.halted         = halt_next;
                fin_res.pc             = pc_next;
                fin_res.executed_count = cnt_next;
                fin_res.reg_written    = rf_req.we;
                fin_res.reg_index      = rf_req.waddr;
                fin_res.reg_value      = rf_req.wdata;
                fin_res.mem_written    = mem_req.we;
                fin_res.mem_address    = mem_req.waddr;
                fin_res.mem_value      = mem_req.wdata;
                if (op == OP_LW) begin
                    state_next = S_LOAD;
                end else begin
                    fin_valid = 1'b1;
                end
            end
            S_LOAD: begin
                rf_req.we              = 1'b1;
                rf_req.waddr           = rb_idx;
                rf_req.wdata           = mem_rdata;
                fin_valid              = 1'b1;
                fin_res.halted         = halt_reg;
                fin_res.pc             = pc_reg;
                fin_res.executed_count = cnt_reg;
                fin_res.reg_written    = 1'b1;
                fin_res.reg_index      = rb_idx;
                fin_res.reg_value      = mem_rdata;
            end
            S_PUSH: begin
                if (out_free) begin
                    out_next     = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_valid) begin
            if (out_free) begin
                out_next     = fin_res;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end else begin
                hold_next  = fin_res;
                state_next = S_PUSH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            halt_reg    <= halt_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        instr_reg <= instr_next;
        out_reg   <= out_next;
        hold_reg  <= hold_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_reg.executed_count, out_reg.mem_value, out_reg.mem_address,
                       out_reg.reg_value, out_reg.reg_index, out_reg.pc};
    assign m_tuser  = {out_reg.mem_written, out_reg.reg_written, out_reg.halted};

    // count only ever steps by one
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (cnt_reg != $past(cnt_reg)) |-> cnt_reg == $past(cnt_reg) + 32'd1)
        else $error("executed count jumped");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(halt_reg) |-> halt_reg)
        else $error("halt flag cleared without reset");

    // a held result exists only behind an occupied output register
    a_push_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PUSH |-> m_valid_reg)
        else $error("result held while output register empty");

    // no step writes both a register and memory
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rf_req.we && mem_req.we))
        else $error("register and memory written together");

    // no memory or register activity after halt except loads
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg && state_reg == S_IDLE |-> !rf_req.we && !mem_req.re)
        else $error("activity after halt");

endmodule

>>> tb/lc2k_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// lc2k_checker
// watches both channels of the lc2k executor, keeps its own copy of the
// machine state, works out the result of every accepted command item and
// compares each returned item field by field in order
// ============================================================================
module lc2k_checker
    import lc2k_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,   // load_address, load_data
    input  logic [0:0]   s_tuser,   // command
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,   // program_counter, reg_index, reg_value,
                                    // mem_address, mem_value, executed_count
    input  logic [2:0]   m_tuser,   // halted, reg_written, mem_written
    output int           errors,
    output int           pending
);

    logic [WORD_W-1:0] word_mem   [0:MEM_WORDS_DEF-1];
    bit                word_valid [0:MEM_WORDS_DEF-1];
    logic [WORD_W-1:0] gpr        [0:NUM_REGS-1];
    logic [ADDR_W-1:0] pc_now;
    logic              halted_now;
    logic [WORD_W-1:0] steps_done;
    res_t              result_q [$];
    int                err_cnt = 0;
    int                wait_cnt = 0;

    assign errors  = err_cnt;
    assign pending = wait_cnt;

    function automatic res_t run_command(input logic cmd, input logic [ADDR_W-1:0] addr,
                                         input logic [WORD_W-1:0] data);
        res_t              r;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] va;
        logic [WORD_W-1:0] vb;
        logic [WORD_W-1:0] off;
        logic [WORD_W-1:0] ea;
        logic [2:0]        ra;
        logic [2:0]        rb;
        logic [ADDR_W-1:0] nxt;
        opcode_t           op;
        r = '0;
        if (cmd == CMD_LOAD) begin
            word_mem[addr]   = data;
            word_valid[addr] = 1'b1;
        end else if (!halted_now) begin
            w   = word_mem[pc_now];
            op  = opcode_t'(w[OP_HI:OP_LO]);
            ra  = w[RA_HI:RA_LO];
            rb  = w[RB_HI:RB_LO];
            va  = gpr[ra];
            vb  = gpr[rb];
            off = {{16{w[OFF_HI]}}, w[15:0]};
            ea  = va + off;
            nxt = pc_now + 16'd1;
            case (op)
                OP_ADD: begin
                    r.reg_written = 1'b1;
                    r.reg_index   = w[RD_HI:RD_LO];
                    r.reg_value   = va + vb;
                end
                OP_NAND: begin
                    r.reg_written = 1'b1;
                    r.reg_index   = w[RD_HI:RD_LO];
                    r.reg_value   = ~(va & vb);
                end
                OP_LW: begin
                    r.reg_written = 1'b1;
                    r.reg_index   = rb;
                    r.reg_value   = word_mem[ea[ADDR_W-1:0]];
                end
                OP_SW: begin
                    r.mem_written = 1'b1;
                    r.mem_address = ea[ADDR_W-1:0];
                    r.mem_value   = vb;
                    word_mem[ea[ADDR_W-1:0]]   = vb;
                    word_valid[ea[ADDR_W-1:0]] = 1'b1;
                end
                OP_BEQ: begin
                    if (va == vb) begin
                        ea  = {16'd0, pc_now} + 32'd1 + off;
                        nxt = ea[ADDR_W-1:0];
                    end
                end
                OP_JALR: begin
                    r.reg_written = 1'b1;
                    r.reg_index   = rb;
                    r.reg_value   = {16'd0, nxt};
                    if (ra != rb) begin
                        nxt = va[ADDR_W-1:0];
                    end
                end
                OP_HALT: begin
                    halted_now = 1'b1;
                end
                default: begin
                end
            endcase
            if (r.reg_written) begin
                gpr[r.reg_index] = r.reg_value;
            end
            pc_now     = nxt;
            steps_done = steps_done + 32'd1;
        end
        r.halted         = halted_now;
        r.pc             = pc_now;
        r.executed_count = steps_done;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t ERROR %s expected %h actual %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin : watch
        res_t want;
        res_t got;
        if (!aresetn) begin
            for (int i = 0; i < MEM_WORDS_DEF; i++) begin
                word_valid[i] = 1'b0;
            end
            for (int i = 0; i < NUM_REGS; i++) begin
                gpr[i] = '0;
            end
            pc_now     = '0;
            halted_now = 1'b0;
            steps_done = '0;
            result_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got                = '0;
                got.pc             = m_tdata[15:0];
                got.reg_index      = m_tdata[18:16];
                got.reg_value      = m_tdata[50:19];
                got.mem_address    = m_tdata[66:51];
                got.mem_value      = m_tdata[98:67];
                got.executed_count = m_tdata[130:99];
                got.halted         = m_tuser[0];
                got.reg_written    = m_tuser[1];
                got.mem_written    = m_tuser[2];
                if (result_q.size() == 0) begin
                    $display("%0t ERROR result item expected none actual pc %h",
                             $time, got.pc);
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    check_field("halted", WORD_W'(want.halted), WORD_W'(got.halted));
                    check_field("program_counter", WORD_W'(want.pc), WORD_W'(got.pc));
                    check_field("reg_written", WORD_W'(want.reg_written),
                                WORD_W'(got.reg_written));
                    check_field("reg_index", WORD_W'(want.reg_index),
                                WORD_W'(got.reg_index));
                    check_field("reg_value", want.reg_value, got.reg_value);
                    check_field("mem_written", WORD_W'(want.mem_written),
                                WORD_W'(got.mem_written));
                    check_field("mem_address", WORD_W'(want.mem_address),
                                WORD_W'(got.mem_address));
                    check_field("mem_value", want.mem_value, got.mem_value);
                    check_field("executed_count", want.executed_count, got.executed_count);
                end
            end
            if (s_tvalid && s_tready) begin
                result_q.push_back(run_command(s_tuser[0], s_tdata[15:0], s_tdata[47:16]));
            end
        end
        wait_cnt = result_q.size();
    end

endmodule

>>> tb/tb_lc2k_instruction_executor.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_lc2k_instruction_executor
// drives load and step commands into the lc2k executor: a short directed
// program over the address and value extremes, then random programs that
// only fetch or load words already written, ending with halt and commands
// after halt; both sides stall at random
// ============================================================================
module tb_lc2k_instruction_executor;
    import lc2k_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1880;
    localparam int QUIET_ITEMS  = 200;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata  = '0;   // load_address, load_data
    logic [0:0]   s_tuser  = '0;   // command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;         // program_counter, reg_index, reg_value,
                                   // mem_address, mem_value, executed_count
    logic [2:0]   m_tuser;         // halted, reg_written, mem_written
    int           errors;
    int           pending;
    bit           quiet = 1'b0;
    int           idle_cycles = 0;
    int           n_loads = 0;
    int           n_steps = 0;
    int           op_hits [0:7];

    lc2k_instruction_executor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lc2k_checker u_chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [WORD_W-1:0] encode(input opcode_t op, input logic [2:0] ra,
                                                 input logic [2:0] rb, input logic [15:0] low);
        return {7'd0, op, ra, rb, low};
    endfunction

    function automatic logic [WORD_W-1:0] rand_insn();
        logic [WORD_W-1:0] w;
        opcode_t           op;
        w  = $urandom;
        op = opcode_t'(3'($urandom_range(0, 5)));
        if ($urandom_range(0, 6) == 0) begin
            op = OP_NOOP;
        end
        w[OP_HI:OP_LO] = op;
        // mostly short offsets so branches form loops
        if ($urandom_range(0, 3) != 0) begin
            w[15:0] = 16'($urandom_range(0, 16));
            w[15:0] = w[15:0] - 16'd8;
        end
        if (op == OP_BEQ && $urandom_range(0, 1) == 1) begin
            w[RB_HI:RB_LO] = w[RA_HI:RA_LO];
        end
        return w;
    endfunction

    // never fetches or loads a word that was not written, and avoids halt
    task automatic pick_item(output logic cmd, output logic [ADDR_W-1:0] addr,
                             output logic [WORD_W-1:0] data);
        logic [ADDR_W-1:0] pc;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] ea;
        pc   = u_chk.pc_now;
        w    = u_chk.word_mem[pc];
        cmd  = CMD_LOAD;
        addr = pc;
        data = rand_insn();
        if ($urandom_range(0, 9) == 0) begin
            addr = 16'($urandom);
            data = $urandom;
        end else if (u_chk.word_valid[pc] && w[OP_HI:OP_LO] != OP_HALT
                     && $urandom_range(0, 3) != 0) begin
            ea = u_chk.gpr[w[RA_HI:RA_LO]] + {{16{w[OFF_HI]}}, w[15:0]};
            if (w[OP_HI:OP_LO] == OP_LW && !u_chk.word_valid[ea[ADDR_W-1:0]]) begin
                addr = ea[ADDR_W-1:0];
                data = $urandom;
            end else begin
                cmd = CMD_STEP;
            end
        end
    endtask

    task automatic push_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] w;
        if (cmd == CMD_STEP) begin
            n_steps++;
            if (!u_chk.halted_now) begin
                w = u_chk.word_mem[u_chk.pc_now];
                op_hits[w[OP_HI:OP_LO]]++;
            end
        end else begin
            n_loads++;
        end
        @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {data, addr};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stim
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
        for (int i = 0; i < 8; i++) begin
            op_hits[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // value extremes, address wrap on lw and pc, jalr both ways
        push_item(CMD_LOAD, 16'hFFFF, 32'h8000_0000);
        push_item(CMD_LOAD, 16'd100, 32'h7FFF_FFFF);
        push_item(CMD_LOAD, 16'd0, encode(OP_LW, 3'd0, 3'd1, 16'd100));
        push_item(CMD_LOAD, 16'd1, encode(OP_LW, 3'd0, 3'd2, 16'hFFFF));
        push_item(CMD_LOAD, 16'd2, encode(OP_ADD, 3'd1, 3'd2, 16'd3) | 32'hFE00_0000);
        push_item(CMD_LOAD, 16'd3, encode(OP_NAND, 3'd1, 3'd2, 16'd4));
        push_item(CMD_LOAD, 16'd4, encode(OP_SW, 3'd0, 3'd3, 16'd200));
        push_item(CMD_LOAD, 16'd5, encode(OP_BEQ, 3'd1, 3'd2, 16'd50));
        push_item(CMD_LOAD, 16'd6, encode(OP_JALR, 3'd5, 3'd5, 16'd0));
        push_item(CMD_LOAD, 16'd7, encode(OP_NOOP, 3'd7, 3'd7, 16'hFFFF));
        push_item(CMD_LOAD, 16'd8, encode(OP_JALR, 3'd4, 3'd6, 16'd0));
        repeat (10) push_item(CMD_STEP, 16'd0, 32'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            if (i == RANDOM_ITEMS / 2) begin
                while (pending != 0) @(negedge aclk);
            end
            pick_item(cmd, addr, data);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            push_item(cmd, addr, data);
        end

        // halt, then steps and a load after halt
        data = $urandom;
        data[OP_HI:OP_LO] = OP_HALT;
        push_item(CMD_LOAD, u_chk.pc_now, data);
        push_item(CMD_STEP, 16'($urandom), $urandom);
        push_item(CMD_STEP, 16'($urandom), $urandom);
        push_item(CMD_LOAD, 16'($urandom), $urandom);
        push_item(CMD_STEP, 16'($urandom), $urandom);

        while (pending != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
        $display("run covered %0d load items and %0d step items", n_loads, n_steps);
        $display("steps by opcode: add %0d nand %0d lw %0d sw %0d beq %0d jalr %0d halt %0d noop %0d",
                 op_hits[OP_ADD], op_hits[OP_NAND], op_hits[OP_LW], op_hits[OP_SW],
                 op_hits[OP_BEQ], op_hits[OP_JALR], op_hits[OP_HALT], op_hits[OP_NOOP]);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
